### hdl/sida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg: shared constants for the signed integer to decimal text unit
// Character codes, conversion step size, queue depth and the digit count helper.
// ----------------------------------------------------------------------------
package sida_pkg;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;

	// Binary bits folded into the BCD register per conversion cycle.
	localparam int STEP_BITS = 4;

	// Entries in the queue between the converter and the emitter.
	localparam int QUEUE_DEPTH = 2;

	// Decimal digits that hold any magnitude up to 2^w - 1.
	function automatic int dec_digits(input int w);
		return (w * 30103) / 100000 + 1;
	endfunction

endpackage

### hdl/sida_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_front: sign split and binary to BCD converter
// Takes an integer, forms its magnitude and converts it to BCD with a
// shift-and-add-3 loop, then pushes sign, digit count and digits to the queue.
// ----------------------------------------------------------------------------
module sida_front #(
	parameter int VALUE_WIDTH = 32,
	parameter int NDIG        = 10,
	parameter int CW          = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   busy,
	output logic                   push_valid,
	input  logic                   push_ready,
	output logic                   push_neg,
	output logic [CW-1:0]          push_ndig,
	output logic [4*NDIG-1:0]      push_bcd
);
	import sida_pkg::*;

	localparam int PW    = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int NSTEP = PW / STEP_BITS;
	localparam int SW    = $clog2(NSTEP);

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_DONE
	} fstate_t;

	fstate_t           state_q;
	logic [SW-1:0]     cnt_q;
	logic [PW-1:0]     mag_q;
	logic [4*NDIG-1:0] bcd_q;
	logic              neg_q;

	logic [VALUE_WIDTH-1:0] mag_c;
	logic [PW-1:0]          mag_n;
	logic [4*NDIG-1:0]      bcd_n;
	logic [CW-1:0]          ndig_c;

	// The most negative value negates to 2^(VALUE_WIDTH-1), which still fits unsigned.
	assign mag_c = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	always_comb begin
		bcd_n = bcd_q;
		mag_n = mag_q;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_n[4*d +: 4] >= 4'd5) begin
					bcd_n[4*d +: 4] = bcd_n[4*d +: 4] + 4'd3;
				end
			end
			bcd_n = {bcd_n[4*NDIG-2:0], mag_n[PW-1]};
			mag_n = {mag_n[PW-2:0], 1'b0};
		end
	end

	// The highest nonzero digit sets the length; zero still has one digit.
	always_comb begin
		ndig_c = CW'(1);
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[4*d +: 4] != 4'd0) begin
				ndig_c = CW'(d + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			mag_q   <= '0;
			bcd_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						mag_q   <= PW'(mag_c);
						bcd_q   <= '0;
						neg_q   <= value[VALUE_WIDTH-1];
						cnt_q   <= '0;
						state_q <= F_CONV;
					end
				end
				F_CONV: begin
					mag_q <= mag_n;
					bcd_q <= bcd_n;
					if (cnt_q == SW'(NSTEP - 1)) begin
						state_q <= F_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				F_DONE: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != F_IDLE);
	assign push_valid = (state_q == F_DONE);
	assign push_neg   = neg_q;
	assign push_ndig  = ndig_c;
	assign push_bcd   = bcd_q;

endmodule

### hdl/sida_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_queue: small register FIFO
// Holds converted numbers between the converter and the character emitter.
// ----------------------------------------------------------------------------
module sida_queue #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import sida_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign in_ready  = (cnt_q != NW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/sida_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_back: character emitter
// Pops converted numbers and sends their text one character per cycle, the
// minus sign first, then digits from the most significant down.
// ----------------------------------------------------------------------------
module sida_back #(
	parameter int NDIG = 10,
	parameter int CW   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  logic              pop_neg,
	input  logic [CW-1:0]     pop_ndig,
	input  logic [4*NDIG-1:0] pop_bcd,
	output logic [7:0]        character,
	output logic              is_last,
	output logic              strobe
);
	import sida_pkg::*;

	localparam int DIW = $clog2(NDIG);

	logic                  active_q;
	logic                  sign_q;
	logic [CW-1:0]         left_q;
	logic [NDIG-1:0][3:0]  bcd_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  strobe_q;

	logic [CW-1:0] pos;
	logic [3:0]    dig;
	logic          finishing;

	assign pos       = left_q - 1'b1;
	assign dig       = bcd_q[pos[DIW-1:0]];
	assign finishing = active_q && !sign_q && (left_q == CW'(1));
	// The next number is loaded while the last digit of this one goes out.
	assign pop_ready = !active_q || finishing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			left_q   <= '0;
			bcd_q    <= '0;
			char_q   <= '0;
			last_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (active_q) begin
				if (sign_q) begin
					char_q <= CH_MINUS;
					last_q <= 1'b0;
				end else begin
					char_q <= CH_ZERO + {4'd0, dig};
					last_q <= (left_q == CW'(1));
				end
			end
			if (pop_valid && pop_ready) begin
				active_q <= 1'b1;
				sign_q   <= pop_neg;
				left_q   <= pop_ndig;
				bcd_q    <= pop_bcd;
			end else if (active_q) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else begin
					left_q <= pos;
					if (left_q == CW'(1)) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	assign character = char_q;
	assign is_last   = last_q;
	assign strobe    = strobe_q;

endmodule

### hdl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed integer to decimal ASCII text
// Converts one two's complement integer per item into its decimal characters.
// ----------------------------------------------------------------------------
// Usage:
// Raise start with value while busy is low; the item is taken at that edge.
// The text comes out on character, one per cycle with strobe high, most
// significant first: a minus sign for negative values, then the digits of
// the magnitude with no leading zeros. is_last marks the final character.
// Zero gives a single '0'; the most negative value gives its full text.
// The converter folds four bits per cycle into BCD, and busy stays high from
// an accept until the result is pushed into the two-entry queue that follows;
// the emitter sends one character per cycle and starts the next number right
// after the last character of the previous one if it is already queued. A
// number passes the queue and is loaded into the emitter, whose character
// register drives the output. Sustained cost per item is the larger of its
// character count (up to 11 at 32 bits) and the converter's time per item.
// The receiver cannot stall: each character is shown for exactly one cycle.
// Reset empties the queue and returns both sides to idle with strobe low.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic [7:0]             character,
	output logic                   is_last,
	output logic                   strobe
);
	import sida_pkg::*;

	localparam int NDIG = dec_digits(VALUE_WIDTH);
	localparam int CW   = $clog2(NDIG + 1);
	localparam int EW   = 1 + CW + 4 * NDIG;

	logic              push_valid;
	logic              push_ready;
	logic              push_neg;
	logic [CW-1:0]     push_ndig;
	logic [4*NDIG-1:0] push_bcd;
	logic              pop_valid;
	logic              pop_ready;
	logic [EW-1:0]     pop_data;

	sida_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NDIG       (NDIG),
		.CW         (CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_neg  (push_neg),
		.push_ndig (push_ndig),
		.push_bcd  (push_bcd)
	);

	sida_queue #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_data  ({push_neg, push_ndig, push_bcd}),
		.out_valid(pop_valid),
		.out_ready(pop_ready),
		.out_data (pop_data)
	);

	sida_back #(
		.NDIG(NDIG),
		.CW  (CW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_neg  (pop_data[EW-1]),
		.pop_ndig (pop_data[EW-2 -: CW]),
		.pop_bcd  (pop_data[4*NDIG-1:0]),
		.character(character),
		.is_last  (is_last),
		.strobe   (strobe)
	);

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for signed_int_to_decimal_ascii_unit
// Sends signed integers, edge values first and then random numbers of every
// length, under three sender pacing mixes. Each accepted item is turned into
// its expected decimal characters, and every strobed character is compared
// in order, character code and last flag separately.
// ----------------------------------------------------------------------------
module testbench;
	import sida_pkg::*;

	localparam int VALUE_WIDTH  = 32;
	localparam int DIGITS_MAX   = 10;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_LIMIT  = 30;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [VALUE_WIDTH-1:0] value;
	logic [7:0]             character;
	logic                   is_last;
	logic                   strobe;

	text_char_t expected_text[$];
	int         gap_pct;
	int         numbers_sent;
	int         negatives_sent;
	int         chars_checked;
	int         mismatch_count;
	int         idle_cycles;

	signed_int_to_decimal_ascii_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.character (character),
		.is_last   (is_last),
		.strobe    (strobe)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
		end
		mismatch_count++;
	endtask

	// Appends the decimal text of one number to the expected characters.
	function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] mag;
		logic [3:0]             digit [DIGITS_MAX];
		int                     ndig;
		int                     i;
		text_char_t             tc;
		mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
		ndig = 0;
		do begin
			digit[ndig] = 4'(mag % 10);
			ndig++;
			mag = mag / 10;
		end while (mag != 0);
		if (v[VALUE_WIDTH-1]) begin
			tc.ch = CH_MINUS;
			tc.last = 1'b0;
			expected_text.push_back(tc);
		end
		for (i = ndig - 1; i >= 0; i--) begin
			tc.ch = CH_ZERO + 8'(digit[i]);
			tc.last = (i == 0);
			expected_text.push_back(tc);
		end
	endfunction

	// Mostly numbers of a random digit count, so that short and long texts
	// are equally common; the rest are raw bit patterns and extremes.
	function automatic logic [VALUE_WIDTH-1:0] random_number();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mag;
		int          ndig;
		logic        neg;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 20) return $urandom;
		if (pick < 25) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				default: return 32'h0;
			endcase
		end
		ndig = $urandom_range(1, DIGITS_MAX);
		neg = 1'($urandom_range(1));
		lo = 64'd1;
		repeat (ndig - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (ndig == 1) lo = 64'd0;
		if (hi > 64'd2147483648) hi = 64'd2147483648;
		mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
		if (!neg && mag == 64'd2147483648) mag = mag - 1;
		return neg ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
	endfunction

	// Each cycle the sender idles with the current gap percentage; otherwise
	// it offers the item, and it keeps trying until the unit takes it.
	task automatic send_number(input logic [VALUE_WIDTH-1:0] v);
		forever begin
			if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end else begin
				start <= 1'b1;
				value <= v;
				@(posedge clk);
				if (!busy) break;
			end
		end
		predict_text(v);
		numbers_sent++;
		if (v[VALUE_WIDTH-1]) negatives_sent++;
	endtask

	task automatic test_edge_values();
		logic [VALUE_WIDTH-1:0] edge_vals[$];
		edge_vals = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
			32'd100, -32'sd100, 32'd12345, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
			32'd1000000000, 32'd999999999, -32'sd1000000000, 32'd1999999999,
			32'h5555_5555, 32'haaaa_aaaa};
		gap_pct = 16;
		foreach (edge_vals[k]) send_number(edge_vals[k]);
	endtask

	task automatic test_random_numbers(input int pct, input int count);
		gap_pct = pct;
		repeat (count) send_number(random_number());
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				report_mismatch("character with none expected", 0, int'(character));
			end else begin
				want = expected_text.pop_front();
				chars_checked++;
				if (character !== want.ch) begin
					report_mismatch("character", int'(want.ch), int'(character));
				end
				if (is_last !== want.last) begin
					report_mismatch("is_last", int'(want.last), int'(is_last));
				end
			end
		end
	end

	// Ends the run when neither an item nor a character moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no traffic for %0d cycles", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		gap_pct = 0;
		numbers_sent = 0;
		negatives_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_values();
		test_random_numbers(16, 100);
		test_random_numbers(63, 100);
		test_random_numbers(0, 100);
		start <= 1'b0;

		while (expected_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d numbers (%0d negative) and checked %0d characters,",
			numbers_sent, negatives_sent, chars_checked);
		$display("with sparse, heavy and no gaps on the sender; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
